/* rtl/cau_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the saturation function for the complex arithmetic unit.
// Depends on nothing; used by every module of the block but cau_div_step.
package cau_pkg;

	// Default fixed-point format, signed Q16.16 in a 32-bit word.
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_W       = 32;

	// Operation codes.
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_INC = 3'd4;
	localparam logic [2:0] OP_DEC = 3'd5;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic [2:0]          operation;
		logic signed [31:0]  a_real;
		logic signed [31:0]  a_imag;
		logic signed [31:0]  b_real;
		logic signed [31:0]  b_imag;
	} req_t;

	typedef struct packed {
		logic signed [31:0]  result_real;
		logic signed [31:0]  result_imag;
		logic [1:0]          status;
	} res_t;

	// Products and sums leaving the front end.
	typedef struct packed {
		logic [2:0]          op;
		logic                bzero;
		logic signed [64:0]  mul_re;
		logic signed [64:0]  mul_im;
		logic signed [64:0]  dnum_re;
		logic signed [64:0]  dnum_im;
		logic [63:0]         den;
		logic signed [32:0]  smp_re;
		logic signed [32:0]  smp_im;
	} front_t;

	// Side band carried alongside the divider stages.
	typedef struct packed {
		logic   is_div;
		logic   bzero;
		logic   neg_re;
		logic   neg_im;
		res_t   direct;
	} side_t;

	typedef struct packed {
		logic [31:0] value;
		logic        ovf;
	} sat_t;

	// Clamp a wide signed value to a signed range of sbits bits.
	function automatic sat_t sat_fn(input logic signed [65:0] x, input int sbits);
		logic signed [65:0] maxv;
		logic signed [65:0] minv;
		sat_t r;
		maxv = $signed((66'd1 << (sbits - 1)) - 66'd1);
		minv = -maxv - 66'sd1;
		r.value = x[31:0];
		r.ovf = 1'b0;
		if (x > maxv) begin
			r.value = maxv[31:0];
			r.ovf = 1'b1;
		end else if (x < minv) begin
			r.value = minv[31:0];
			r.ovf = 1'b1;
		end
		return r;
	endfunction

endpackage

/* rtl/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Top level of the complex arithmetic unit: front end, divider pipeline and result stage.
// Depends on cau_pkg, cau_front and cau_div_pipe.
//
// Usage:
// A request on req_data carries an operation code and two complex operands in
// signed fixed point; it is taken at a clock edge where req_valid is high and
// req_stall is low. Each request gives exactly one result on res_data, with
// res_valid high, taken when res_stall is low. Results leave in request order.
// Every operation runs through the same pipeline of 37 register stages: the
// multipliers, the sums, operand selection and saturation, the divider range
// check, the 32 restoring divider steps (one quotient bit per stage) and the
// output register. A new request can be taken in every cycle in which
// req_stall is low, so the throughput is one request per cycle while the
// receiver does not stall. While a result waits in the output register and
// the receiver stalls, the whole pipeline holds and req_stall is raised;
// empty stages hold as well. Reset clears every valid bit; no result is
// presented until a request has passed through.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cau_pkg::req_t  req_data,
	output logic           res_valid,
	input  logic           res_stall,
	output cau_pkg::res_t  res_data
);

	localparam int SAT_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;
	localparam logic signed [65:0] BIG  = 66'sd1 <<< 40;
	localparam logic signed [65:0] MAXW = (66'sd1 <<< (SAT_BITS - 1)) - 66'sd1;
	localparam logic signed [65:0] MINW = -MAXW - 66'sd1;

	logic             en;
	logic             f_valid;
	cau_pkg::front_t  f_data;
	logic             valid_s3;
	cau_pkg::side_t   side_s3;
	logic [63:0]      mag_re_s3, mag_im_s3, den_s3;
	logic             d_valid;
	cau_pkg::side_t   d_side;
	logic [31:0]      q_re, q_im;
	logic             d_ovf_re, d_ovf_im;

	logic signed [65:0] w_re, w_im;
	logic signed [64:0] n_re, n_im;
	cau_pkg::sat_t      s_re, s_im;
	cau_pkg::side_t     side_d;
	logic signed [65:0] x_re, x_im;
	cau_pkg::sat_t      r_re, r_im;
	cau_pkg::res_t      res_d;

	// The pipeline moves unless a finished result is held by the receiver.
	assign en        = !res_valid || !res_stall;
	assign req_stall = !en;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.in_data   (req_data),
		.out_valid (f_valid),
		.out_data  (f_data)
	);

	// Direct result for all but divide, and dividend magnitudes for divide.
	always_comb begin
		case (f_data.op)
			cau_pkg::OP_MUL: begin
				w_re = 66'(f_data.mul_re) >>> FRAC_BITS;
				w_im = 66'(f_data.mul_im) >>> FRAC_BITS;
			end
			cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_INC, cau_pkg::OP_DEC: begin
				w_re = 66'(f_data.smp_re);
				w_im = 66'(f_data.smp_im);
			end
			default: begin
				w_re = 66'sd0;
				w_im = 66'sd0;
			end
		endcase
		s_re = cau_pkg::sat_fn(w_re, SAT_BITS);
		s_im = cau_pkg::sat_fn(w_im, SAT_BITS);
		n_re = -f_data.dnum_re;
		n_im = -f_data.dnum_im;
		side_d.is_div             = (f_data.op == cau_pkg::OP_DIV);
		side_d.bzero              = f_data.bzero;
		side_d.neg_re             = f_data.dnum_re[64];
		side_d.neg_im             = f_data.dnum_im[64];
		side_d.direct.result_real = s_re.value;
		side_d.direct.result_imag = s_im.value;
		side_d.direct.status      = (s_re.ovf || s_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= f_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3   <= side_d;
			mag_re_s3 <= f_data.dnum_re[64] ? n_re[63:0] : f_data.dnum_re[63:0];
			mag_im_s3 <= f_data.dnum_im[64] ? n_im[63:0] : f_data.dnum_im[63:0];
			den_s3    <= f_data.den;
		end
	end

	cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_side   (side_s3),
		.mag_re    (mag_re_s3),
		.mag_im    (mag_im_s3),
		.den       (den_s3),
		.out_valid (d_valid),
		.out_side  (d_side),
		.q_re      (q_re),
		.q_im      (q_im),
		.ovf_re    (d_ovf_re),
		.ovf_im    (d_ovf_im)
	);

	// Signed quotients, saturated, and the final choice of result.
	always_comb begin
		if (d_ovf_re) begin
			x_re = d_side.neg_re ? -BIG : BIG;
		end else begin
			x_re = d_side.neg_re ? -$signed({34'd0, q_re}) : $signed({34'd0, q_re});
		end
		if (d_ovf_im) begin
			x_im = d_side.neg_im ? -BIG : BIG;
		end else begin
			x_im = d_side.neg_im ? -$signed({34'd0, q_im}) : $signed({34'd0, q_im});
		end
		r_re = cau_pkg::sat_fn(x_re, SAT_BITS);
		r_im = cau_pkg::sat_fn(x_im, SAT_BITS);
		if (!d_side.is_div) begin
			res_d = d_side.direct;
		end else if (d_side.bzero) begin
			res_d.result_real = 32'sd0;
			res_d.result_imag = 32'sd0;
			res_d.status      = cau_pkg::ST_DIVZ;
		end else begin
			res_d.result_real = r_re.value;
			res_d.result_imag = r_im.value;
			res_d.status      = (r_re.ovf || r_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_data <= res_d;
		end
	end

	// A zero divisor always yields a zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == cau_pkg::ST_DIVZ) |->
		(res_data.result_real == 32'sd0) && (res_data.result_imag == 32'sd0))
		else $error("divide by zero result is not zero");

	// The unused status code never appears.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.status != 2'd3))
		else $error("invalid status code");

	// A saturation status means at least one part sits on a bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == cau_pkg::ST_OVF) |->
		(res_data.result_real == MAXW[31:0]) || (res_data.result_real == MINW[31:0]) ||
		(res_data.result_imag == MAXW[31:0]) || (res_data.result_imag == MINW[31:0]))
		else $error("saturation flagged without a clamped part");

endmodule

/* rtl/cau_front.sv */
`timescale 1ns / 1ps
// Front end of the complex arithmetic unit: the multipliers and the sums of products.
// Depends on cau_pkg.
module cau_front #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  cau_pkg::req_t        in_data,
	output logic                 out_valid,
	output cau_pkg::front_t      out_data
);

	localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

	logic               valid_s1;
	logic               valid_s2;
	logic [2:0]         op_s1;
	logic               bzero_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_r_s1, sq_i_s1;
	cau_pkg::front_t    f_s2;
	logic signed [32:0] smp_re, smp_im;

	// Valid bits advance with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: the six 32 by 32 products.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= in_data.operation;
			bzero_s1 <= (in_data.b_real == 32'sd0) && (in_data.b_imag == 32'sd0);
			ar_s1    <= in_data.a_real;
			ai_s1    <= in_data.a_imag;
			br_s1    <= in_data.b_real;
			bi_s1    <= in_data.b_imag;
			p_rr_s1  <= in_data.a_real * in_data.b_real;
			p_ii_s1  <= in_data.a_imag * in_data.b_imag;
			p_ri_s1  <= in_data.a_real * in_data.b_imag;
			p_ir_s1  <= in_data.a_imag * in_data.b_real;
			sq_r_s1  <= in_data.b_real * in_data.b_real;
			sq_i_s1  <= in_data.b_imag * in_data.b_imag;
		end
	end

	// Simple operations that need only one add.
	always_comb begin
		case (op_s1)
			cau_pkg::OP_ADD: begin
				smp_re = 33'(ar_s1) + 33'(br_s1);
				smp_im = 33'(ai_s1) + 33'(bi_s1);
			end
			cau_pkg::OP_SUB: begin
				smp_re = 33'(ar_s1) - 33'(br_s1);
				smp_im = 33'(ai_s1) - 33'(bi_s1);
			end
			cau_pkg::OP_INC: begin
				smp_re = 33'(ar_s1) + ONE;
				smp_im = 33'(ai_s1) + ONE;
			end
			cau_pkg::OP_DEC: begin
				smp_re = 33'(ar_s1) - ONE;
				smp_im = 33'(ai_s1) - ONE;
			end
			default: begin
				smp_re = 33'sd0;
				smp_im = 33'sd0;
			end
		endcase
	end

	// Stage two: sums of products and the squared magnitude of the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s2.op      <= op_s1;
			f_s2.bzero   <= bzero_s1;
			f_s2.mul_re  <= 65'(p_rr_s1) - 65'(p_ii_s1);
			f_s2.mul_im  <= 65'(p_ri_s1) + 65'(p_ir_s1);
			f_s2.dnum_re <= 65'(p_rr_s1) + 65'(p_ii_s1);
			f_s2.dnum_im <= 65'(p_ir_s1) - 65'(p_ri_s1);
			f_s2.den     <= $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
			f_s2.smp_re  <= smp_re;
			f_s2.smp_im  <= smp_im;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = f_s2;

endmodule

/* rtl/cau_div_step.sv */
`timescale 1ns / 1ps
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on nothing.
module cau_div_step (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rem_in,
	input  logic [31:0] lw_in,
	input  logic [63:0] den,
	output logic [63:0] rem_out,
	output logic [31:0] lw_out
);

	logic [64:0] shifted;
	logic [65:0] diff;
	logic        take;

	// Bring in the next dividend bit and try to subtract the divisor.
	always_comb begin
		shifted = {rem_in, lw_in[31]};
		diff    = {1'b0, shifted} - {2'b00, den};
		take    = !diff[65];
	end

	// The low word shifts out dividend bits and shifts in quotient bits.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? diff[63:0] : shifted[63:0];
			lw_out  <= {lw_in[30:0], take};
		end
	end

endmodule

/* rtl/cau_div_pipe.sv */
`timescale 1ns / 1ps
// Pipelined divider for both result parts: a range check stage and 32 restoring steps.
// Depends on cau_pkg and cau_div_step.
module cau_div_pipe #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  cau_pkg::side_t  in_side,
	input  logic [63:0]     mag_re,
	input  logic [63:0]     mag_im,
	input  logic [63:0]     den,
	output logic            out_valid,
	output cau_pkg::side_t  out_side,
	output logic [31:0]     q_re,
	output logic [31:0]     q_im,
	output logic            ovf_re,
	output logic            ovf_im
);

	localparam int MW    = 64 + FRAC_BITS;
	localparam int NSTEP = 32;

	logic [MW-1:0] m_re, m_im;
	logic [63:0]   hi_re, hi_im;

	// Index 0 is the range check stage, index k the output of step k.
	logic             valid_s  [0:NSTEP];
	cau_pkg::side_t   side_s   [0:NSTEP];
	logic [63:0]      den_s    [0:NSTEP];
	logic             ovf_re_s [0:NSTEP];
	logic             ovf_im_s [0:NSTEP];
	logic [63:0]      rem_re_s [0:NSTEP];
	logic [63:0]      rem_im_s [0:NSTEP];
	logic [31:0]      lw_re_s  [0:NSTEP];
	logic [31:0]      lw_im_s  [0:NSTEP];

	// Scaled dividend; its part above bit 31 must stay below the divisor.
	always_comb begin
		m_re  = MW'(mag_re) << FRAC_BITS;
		m_im  = MW'(mag_im) << FRAC_BITS;
		hi_re = 64'(m_re[MW-1:32]);
		hi_im = 64'(m_im[MW-1:32]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	// Range check: a quotient of 2^32 or more saturates whatever its low bits.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0]   <= in_side;
			den_s[0]    <= den;
			ovf_re_s[0] <= hi_re >= den;
			ovf_im_s[0] <= hi_im >= den;
			rem_re_s[0] <= hi_re;
			rem_im_s[0] <= hi_im;
			lw_re_s[0]  <= m_re[31:0];
			lw_im_s[0]  <= m_im[31:0];
		end
	end

	// The restoring steps, with the side band travelling beside them.
	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k]   <= side_s[k-1];
				den_s[k]    <= den_s[k-1];
				ovf_re_s[k] <= ovf_re_s[k-1];
				ovf_im_s[k] <= ovf_im_s[k-1];
			end
		end

		cau_div_step u_step_re (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_re_s[k-1]),
			.lw_in   (lw_re_s[k-1]),
			.den     (den_s[k-1]),
			.rem_out (rem_re_s[k]),
			.lw_out  (lw_re_s[k])
		);

		cau_div_step u_step_im (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_im_s[k-1]),
			.lw_in   (lw_im_s[k-1]),
			.den     (den_s[k-1]),
			.rem_out (rem_im_s[k]),
			.lw_out  (lw_im_s[k])
		);
	end

	assign out_valid = valid_s[NSTEP];
	assign out_side  = side_s[NSTEP];
	assign q_re      = lw_re_s[NSTEP];
	assign q_im      = lw_im_s[NSTEP];
	assign ovf_re    = ovf_re_s[NSTEP];
	assign ovf_im    = ovf_im_s[NSTEP];

endmodule
